[rtl/core/isq_pkg.sv]
// Shared constants and codes for the interval set block.
package isq_pkg;

  localparam int DEF_MAX_INTERVALS = 64;
  localparam int DEF_VALUE_BITS    = 32;

  localparam int CMD_BITS = 2;
  localparam int ANS_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [ANS_BITS-1:0] ANS_NO    = 2'd0;
  localparam logic [ANS_BITS-1:0] ANS_MAYBE = 2'd1;
  localparam logic [ANS_BITS-1:0] ANS_YES   = 2'd2;

endpackage

[rtl/core/isq_req_if.sv]
// Command channel carrying one insert, query or clear.
interface isq_req_if #(
  parameter int VALUE_BITS = isq_pkg::DEF_VALUE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [isq_pkg::CMD_BITS-1:0]  command;
  logic [VALUE_BITS-1:0]         low_bound;
  logic [VALUE_BITS-1:0]         high_bound;
  logic                          exact_in;
  logic [VALUE_BITS-1:0]         point;

  modport source (output valid, command, low_bound, high_bound, exact_in, point,
                  input ready);
  modport sink (input valid, command, low_bound, high_bound, exact_in, point,
                output ready);
endinterface

[rtl/core/isq_rsp_if.sv]
// Result channel carrying one answer per command.
interface isq_rsp_if #(
  parameter int COUNT_BITS = $clog2(isq_pkg::DEF_MAX_INTERVALS + 1)
);
  logic                          valid;
  logic                          ready;
  logic [isq_pkg::ANS_BITS-1:0]  answer;
  logic                          dropped;
  logic [COUNT_BITS-1:0]         entries_in_use;

  modport source (output valid, answer, dropped, entries_in_use, input ready);
  modport sink (input valid, answer, dropped, entries_in_use, output ready);
endinterface

[rtl/core/interval_set_merge_and_query.sv]
// Sorted disjoint interval set: merge on insert, point query, clear.
// Entries are scanned through the single RAM read port; an insert shifts the
//   entries that follow it to make room or to close a gap.
// Throughput: one command at a time; next command taken once the result is
//   registered. Reset empties the table at once; no RAM clearing pass.
module interval_set_merge_and_query #(
  parameter int MAX_INTERVALS = isq_pkg::DEF_MAX_INTERVALS,
  parameter int VALUE_BITS    = isq_pkg::DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  isq_req_if.sink     req,
  isq_rsp_if.source   rsp
);
  import isq_pkg::*;

  localparam int IW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int EW = 2 * VALUE_BITS + 1;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_EV  = 8'b0000_0100,
    S_DECIDE   = 8'b0000_1000,
    S_SHIFT_RD = 8'b0001_0000,
    S_SHIFT_WR = 8'b0010_0000,
    S_PLACE    = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  state_t                state;
  logic                  is_query;
  logic [VALUE_BITS-1:0] ka, kb, lo_f, hi_l;
  logic                  kex, found, nex, shift_up, drop;
  logic [CW-1:0]         idx, cnt;
  logic [IW-1:0]         first, last, pos, dst;
  logic [ANS_BITS-1:0]   ans;
  logic                  out_valid;
  logic [ANS_BITS-1:0]   out_ans;
  logic                  out_drop;
  logic [CW-1:0]         out_cnt;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [EW-1:0]         ram_wdata, ram_rdata;
  logic [VALUE_BITS-1:0] r_lo, r_hi;
  logic                  r_ex, touch;
  logic [IW-1:0]         gone;
  logic [CW-1:0]         idx_p1, idx_m1, last_p1;

  isq_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign r_lo    = ram_rdata[EW-1 -: VALUE_BITS];
  assign r_hi    = ram_rdata[VALUE_BITS:1];
  assign r_ex    = ram_rdata[0];
  assign gone    = last - first;
  assign idx_p1  = idx + CW'(1);
  assign idx_m1  = idx - CW'(1);
  assign last_p1 = CW'(last) + CW'(1);

  // overlap or adjacency within one value
  assign touch = !((ka > r_hi) && ((ka - r_hi) != VALUE_BITS'(1))) &&
                 !((kb < r_lo) && ((r_lo - kb) != VALUE_BITS'(1)));

  always_comb begin
    ram_we    = 1'b0;
    ram_raddr = idx[IW-1:0];
    ram_waddr = dst;
    ram_wdata = ram_rdata;
    if (state == S_SHIFT_RD && shift_up) begin
      ram_raddr = idx_m1[IW-1:0];
    end
    if (state == S_SHIFT_WR) begin
      ram_we    = 1'b1;
      ram_waddr = shift_up ? idx[IW-1:0] : (idx[IW-1:0] - gone);
    end else if (state == S_PLACE) begin
      ram_we = 1'b1;
      if (shift_up) begin
        ram_wdata = {ka, kb, kex};
      end else begin
        ram_wdata = {((ka < lo_f) ? ka : lo_f), ((kb > hi_l) ? kb : hi_l), nex & kex};
      end
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.answer         = out_ans;
  assign rsp.dropped        = out_drop;
  assign rsp.entries_in_use = out_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // the result state reloads the output register itself
      if (out_valid && rsp.ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            is_query <= (req.command == CMD_QUERY);
            ka       <= (req.command == CMD_QUERY) ? req.point : req.low_bound;
            kb       <= req.high_bound;
            kex      <= req.exact_in;
            ans      <= ANS_NO;
            drop     <= 1'b0;
            found    <= 1'b0;
            nex      <= 1'b1;
            pos      <= '0;
            idx      <= '0;
            unique case (req.command)
              CMD_INSERT: begin
                if (req.high_bound < req.low_bound) state <= S_RESP;
                else if (cnt == '0)                 state <= S_DECIDE;
                else                                state <= S_SCAN_RD;
              end
              CMD_QUERY: state <= (cnt == '0) ? S_RESP : S_SCAN_RD;
              CMD_CLEAR: begin
                cnt   <= '0;
                state <= S_RESP;
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV: begin
          idx   <= idx_p1;
          state <= (idx_p1 == cnt) ? (is_query ? S_RESP : S_DECIDE) : S_SCAN_RD;
          if (is_query) begin
            if (r_lo <= ka && ka <= r_hi) begin
              ans   <= r_ex ? ANS_YES : ANS_MAYBE;
              state <= S_RESP;
            end
          end else if (touch) begin
            if (!found) begin
              first <= idx[IW-1:0];
              lo_f  <= r_lo;
            end
            found <= 1'b1;
            last  <= idx[IW-1:0];
            hi_l  <= r_hi;
            nex   <= nex & r_ex;
          end else if (r_hi < ka) begin
            pos <= idx[IW-1:0] + IW'(1);
          end
        end
        S_DECIDE: begin
          if (!found) begin
            if (cnt == CW'(MAX_INTERVALS)) begin
              drop  <= 1'b1;
              state <= S_RESP;
            end else begin
              shift_up <= 1'b1;
              dst      <= pos;
              idx      <= cnt;
              state    <= (cnt > CW'(pos)) ? S_SHIFT_RD : S_PLACE;
            end
          end else if (!kex && first == last && lo_f <= ka && kb <= hi_l) begin
            state <= S_RESP;
          end else begin
            shift_up <= 1'b0;
            dst      <= first;
            state    <= S_PLACE;
          end
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          if (shift_up) begin
            idx   <= idx_m1;
            state <= (idx_m1 > CW'(pos)) ? S_SHIFT_RD : S_PLACE;
          end else begin
            idx <= idx_p1;
            if (idx_p1 < cnt) begin
              state <= S_SHIFT_RD;
            end else begin
              cnt   <= cnt - CW'(gone);
              state <= S_RESP;
            end
          end
        end
        S_PLACE: begin
          if (shift_up) begin
            cnt   <= cnt + CW'(1);
            state <= S_RESP;
          end else begin
            // close the gap left by absorbed entries
            idx <= last_p1;
            if (last_p1 < cnt) begin
              state <= S_SHIFT_RD;
            end else begin
              cnt   <= cnt - CW'(gone);
              state <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_ans   <= ans;
            out_drop  <= drop;
            out_cnt   <= cnt;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/isq_ram.sv]
// Generic simple dual-port RAM with registered read.
module isq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/isq_checker.sv]
// Port-level checks for the interval set block, bound to the top level.
module isq_checker #(
  parameter int MAX_INTERVALS = isq_pkg::DEF_MAX_INTERVALS
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_valid,
  input logic                                 req_ready,
  input logic                                 rsp_valid,
  input logic                                 rsp_ready,
  input logic [isq_pkg::ANS_BITS-1:0]         answer,
  input logic                                 dropped,
  input logic [$clog2(MAX_INTERVALS+1)-1:0]   entries_in_use
);
  import isq_pkg::*;

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command taken while previous one still in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(answer) && $stable(dropped)
      && $stable(entries_in_use))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entries_in_use <= CW'(MAX_INTERVALS))
    else $error("entry count beyond capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && dropped |-> entries_in_use == CW'(MAX_INTERVALS) && answer == ANS_NO)
    else $error("drop reported with free room or with an answer");
endmodule

bind interval_set_merge_and_query isq_checker #(.MAX_INTERVALS(MAX_INTERVALS)) u_isq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .answer         (rsp.answer),
  .dropped        (rsp.dropped),
  .entries_in_use (rsp.entries_in_use)
);
